@@ rtl/assert_macros.svh @@
// Assertion macros shared by the covariance block; they expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SCM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define SCM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/scm_pkg.sv @@
// Shared constants, controller states and command/status types of the covariance block.
`default_nettype none

package scm_pkg;

	// Default sizing
	localparam int MAX_VARS_DEF     = 8;
	localparam int MAX_PATTERNS_DEF = 1024;
	localparam int SAMPLE_BITS_DEF  = 16;

	// Fixed field widths
	localparam int CFG_W      = 4;
	localparam int IDX_W      = 3;
	localparam int COV_W      = 40;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int REG_IDX_W  = 1;

	// Register map
	localparam logic [REG_IDX_W-1:0] REG_VARS_IN_USE = 1'b0;
	localparam logic [CFG_W-1:0]     VARS_RESET      = 4'd8;

	// Saturation limits of a Q24.16 result
	localparam logic signed [63:0] COV_MAX = 64'sd549755813887;
	localparam logic signed [63:0] COV_MIN = -64'sd549755813888;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CHECK,
		ST_MEAN_CLR,
		ST_MEAN_RD,
		ST_MEAN_DRAIN,
		ST_MEAN_DIV,
		ST_COV_CLR,
		ST_COV_RD,
		ST_COV_DRAIN,
		ST_COV_DIV,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	typedef struct packed {
		logic load_en;    // accept sample words
		logic sweep_clr;  // clear accumulator and sweep pointer
		logic sweep_rd;   // read one pattern into the pipeline
		logic cov_mode;   // centered products instead of plain sums
		logic div_start;  // start the shared divider
		logic mean_wr;    // store quotient as a mean
		logic tri_wr;     // store saturated quotient in the triangle
		logic out_load;   // load the output register
		logic out_last;   // final entry of the run
		logic restart;    // clear load counters
	} cmd_t;

	typedef struct packed {
		logic last_in;    // accepted word closes the data set
		logic err;        // too few patterns or store overflow
		logic pipe_busy;  // product pipeline not drained
		logic div_done;   // quotient ready
		logic out_free;   // output register can take a word
	} sts_t;

endpackage

`default_nettype wire

@@ rtl/scm_if.sv @@
// Valid/ready channel interfaces for sample words and covariance entries.
`default_nettype none

interface scm_in_if #(
	parameter int SAMPLE_BITS = scm_pkg::SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_value;
	logic                          last_of_set;

	modport source (output valid, sample_value, last_of_set, input ready);
	modport sink (input valid, sample_value, last_of_set, output ready);
endinterface

interface scm_out_if ();
	logic                              valid;
	logic                              ready;
	logic [scm_pkg::IDX_W-1:0]         row_index;
	logic [scm_pkg::IDX_W-1:0]         col_index;
	logic signed [scm_pkg::COV_W-1:0]  cov_value;
	logic                              error_flag;
	logic                              last_entry;

	modport source (output valid, row_index, col_index, cov_value, error_flag, last_entry,
		input ready);
	modport sink (input valid, row_index, col_index, cov_value, error_flag, last_entry,
		output ready);
endinterface

`default_nettype wire

@@ rtl/scm_divider.sv @@
// Shared radix-2 restoring divider: signed dividend, positive divisor, truncating quotient.
`default_nettype none

module scm_divider #(
	parameter int DIV_W = 44,
	parameter int DVS_W = 11,
	localparam int CNT_W = $clog2(DIV_W + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0]        divisor,
	output logic                    done,
	output logic signed [DIV_W-1:0] quotient
);

	logic              busy_q;
	logic              fin_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;
	logic [DIV_W-1:0]  mag_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic signed [DIV_W-1:0] quot_q;

	logic [DVS_W:0]    rem_sh;
	logic              fits;
	logic [DVS_W-1:0]  rem_nx;

	// One quotient bit per cycle
	always_comb begin
		rem_sh = {rem_q, mag_q[DIV_W-1]};
		fits   = rem_sh >= {1'b0, dvs_q};
		rem_nx = fits ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
	end

	// Sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	// Work on magnitudes, apply the sign at the end
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DIV_W-1];
			mag_q <= dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			mag_q <= {mag_q[DIV_W-2:0], fits};
			rem_q <= rem_nx;
		end
		if (fin_q) begin
			quot_q <= neg_q ? -$signed(mag_q) : $signed(mag_q);
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

`default_nettype wire

@@ rtl/scm_ctrl.sv @@
// Controller of the covariance block: load, mean sweeps, covariance sweeps and emission.
`default_nettype none
`include "assert_macros.svh"

module scm_ctrl #(
	parameter int MAX_VARS     = scm_pkg::MAX_VARS_DEF,
	parameter int MAX_PATTERNS = scm_pkg::MAX_PATTERNS_DEF,
	localparam int VAR_W  = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1,
	localparam int VCNT_W = $clog2(MAX_VARS + 1),
	localparam int CMP_W  = VCNT_W + 1,
	localparam int CNT_W  = $clog2(MAX_PATTERNS + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [VCNT_W-1:0]    vars,
	input  logic [CNT_W-1:0]     n_patterns,
	input  scm_pkg::sts_t        sts,
	output scm_pkg::cmd_t        cmd,
	output logic [VAR_W-1:0]     row_sel,
	output logic [VAR_W-1:0]     col_sel
);

	scm_pkg::state_t state_q, state_d;
	logic [VAR_W-1:0] j_q, j_d;
	logic [VAR_W-1:0] k_q, k_d;
	logic [CNT_W-1:0] p_q, p_d;

	logic j_end;
	logic k_end;
	logic p_end;

	assign j_end = (CMP_W'(j_q) + CMP_W'(1)) == CMP_W'(vars);
	assign k_end = (CMP_W'(k_q) + CMP_W'(1)) == CMP_W'(vars);
	assign p_end = (p_q + CNT_W'(1)) == n_patterns;

	// State and loop indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scm_pkg::ST_LOAD;
			j_q     <= '0;
			k_q     <= '0;
			p_q     <= '0;
		end else begin
			state_q <= state_d;
			j_q     <= j_d;
			k_q     <= k_d;
			p_q     <= p_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		j_d     = j_q;
		k_d     = k_q;
		p_d     = p_q;
		cmd     = '0;
		unique case (state_q)
			scm_pkg::ST_LOAD: begin
				cmd.load_en = 1'b1;
				if (sts.last_in) begin
					state_d = scm_pkg::ST_CHECK;
				end
			end
			scm_pkg::ST_CHECK: begin
				j_d = '0;
				k_d = '0;
				state_d = sts.err ? scm_pkg::ST_EMIT_RD : scm_pkg::ST_MEAN_CLR;
			end
			scm_pkg::ST_MEAN_CLR: begin
				cmd.sweep_clr = 1'b1;
				p_d = '0;
				state_d = scm_pkg::ST_MEAN_RD;
			end
			scm_pkg::ST_MEAN_RD: begin
				cmd.sweep_rd = 1'b1;
				if (p_end) begin
					state_d = scm_pkg::ST_MEAN_DRAIN;
				end else begin
					p_d = p_q + CNT_W'(1);
				end
			end
			scm_pkg::ST_MEAN_DRAIN: begin
				if (!sts.pipe_busy) begin
					cmd.div_start = 1'b1;
					state_d = scm_pkg::ST_MEAN_DIV;
				end
			end
			scm_pkg::ST_MEAN_DIV: begin
				if (sts.div_done) begin
					cmd.mean_wr = 1'b1;
					if (j_end) begin
						j_d = '0;
						k_d = '0;
						state_d = scm_pkg::ST_COV_CLR;
					end else begin
						j_d = j_q + VAR_W'(1);
						state_d = scm_pkg::ST_MEAN_CLR;
					end
				end
			end
			scm_pkg::ST_COV_CLR: begin
				cmd.cov_mode  = 1'b1;
				cmd.sweep_clr = 1'b1;
				p_d = '0;
				state_d = scm_pkg::ST_COV_RD;
			end
			scm_pkg::ST_COV_RD: begin
				cmd.cov_mode = 1'b1;
				cmd.sweep_rd = 1'b1;
				if (p_end) begin
					state_d = scm_pkg::ST_COV_DRAIN;
				end else begin
					p_d = p_q + CNT_W'(1);
				end
			end
			scm_pkg::ST_COV_DRAIN: begin
				cmd.cov_mode = 1'b1;
				if (!sts.pipe_busy) begin
					cmd.div_start = 1'b1;
					state_d = scm_pkg::ST_COV_DIV;
				end
			end
			scm_pkg::ST_COV_DIV: begin
				cmd.cov_mode = 1'b1;
				if (sts.div_done) begin
					cmd.tri_wr = 1'b1;
					if (k_end && j_end) begin
						j_d = '0;
						k_d = '0;
						state_d = scm_pkg::ST_EMIT_RD;
					end else if (k_end) begin
						j_d = j_q + VAR_W'(1);
						k_d = j_q + VAR_W'(1);
						state_d = scm_pkg::ST_COV_CLR;
					end else begin
						k_d = k_q + VAR_W'(1);
						state_d = scm_pkg::ST_COV_CLR;
					end
				end
			end
			scm_pkg::ST_EMIT_RD: begin
				state_d = scm_pkg::ST_EMIT_LD;
			end
			scm_pkg::ST_EMIT_LD: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = j_end && k_end;
					if (j_end && k_end) begin
						cmd.restart = 1'b1;
						j_d = '0;
						k_d = '0;
						state_d = scm_pkg::ST_LOAD;
					end else if (k_end) begin
						j_d = j_q + VAR_W'(1);
						k_d = '0;
						state_d = scm_pkg::ST_EMIT_RD;
					end else begin
						k_d = k_q + VAR_W'(1);
						state_d = scm_pkg::ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = scm_pkg::ST_LOAD;
			end
		endcase
	end

	assign row_sel = j_q;
	assign col_sel = k_q;

	`SCM_ASSERT_IMP(a_done_in_div, sts.div_done, state_q == scm_pkg::ST_MEAN_DIV || state_q == scm_pkg::ST_COV_DIV, "quotient arrived outside a divide state")
	`SCM_ASSERT_IMP(a_pipe_in_sweep, sts.pipe_busy, state_q == scm_pkg::ST_MEAN_RD || state_q == scm_pkg::ST_MEAN_DRAIN || state_q == scm_pkg::ST_COV_RD || state_q == scm_pkg::ST_COV_DRAIN, "samples in flight outside a sweep")
	`SCM_ASSERT_IMP(a_no_math_on_error, cmd.sweep_rd || cmd.div_start, !sts.err, "computing on an error run")
	`SCM_ASSERT_NXT(a_run_ends_in_load, cmd.out_load && cmd.out_last, state_q == scm_pkg::ST_LOAD && n_patterns == '0, "run did not return to loading")

endmodule

`default_nettype wire

@@ rtl/scm_datapath.sv @@
// Datapath: sample store, load counters, centered product pipeline, divider, result stores.
`default_nettype none

module scm_datapath #(
	parameter int MAX_VARS     = scm_pkg::MAX_VARS_DEF,
	parameter int MAX_PATTERNS = scm_pkg::MAX_PATTERNS_DEF,
	parameter int SAMPLE_BITS  = scm_pkg::SAMPLE_BITS_DEF,
	localparam int VAR_W     = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1,
	localparam int VCNT_W    = $clog2(MAX_VARS + 1),
	localparam int CMP_W     = VCNT_W + 1,
	localparam int CNT_W     = $clog2(MAX_PATTERNS + 1),
	localparam int SDEPTH    = MAX_VARS * MAX_PATTERNS,
	localparam int SADDR_W   = $clog2(SDEPTH),
	localparam int SBASE_W   = $clog2(SDEPTH + 1),
	localparam int DIFF_W    = SAMPLE_BITS + 1,
	localparam int PROD_W    = 2 * DIFF_W,
	localparam int ACC_RAW   = 2 * SAMPLE_BITS + CNT_W + 1,
	localparam int ACC_W     = (ACC_RAW > 64) ? 64 : ACC_RAW,
	localparam int TRI_DEPTH = 1 << (2 * VAR_W)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	scm_in_if.sink                samples,
	scm_out_if.source             entries,
	input  scm_pkg::cmd_t         cmd,
	input  logic [VAR_W-1:0]      row_sel,
	input  logic [VAR_W-1:0]      col_sel,
	input  logic [VCNT_W-1:0]     vars,
	output scm_pkg::sts_t         sts,
	output logic [CNT_W-1:0]      n_patterns
);

	// Load counters
	logic [CNT_W-1:0]   pc_q;
	logic [VAR_W-1:0]   var_q;
	logic [SBASE_W-1:0] wr_base_q;
	logic               ovf_q;
	logic               accept;
	logic               room;
	logic               store_we;
	logic [SADDR_W-1:0] store_waddr;

	// Sweep pipeline
	logic [SBASE_W-1:0]             rd_base_q;
	logic [SADDR_W-1:0]             rd_addr_a;
	logic [SADDR_W-1:0]             rd_addr_b;
	logic signed [SAMPLE_BITS-1:0]  store_mem [SDEPTH];
	logic signed [SAMPLE_BITS-1:0]  rd_a_s1;
	logic signed [SAMPLE_BITS-1:0]  rd_b_s1;
	logic                           vld_s1;
	logic signed [DIFF_W-1:0]       da_s2;
	logic signed [DIFF_W-1:0]       db_s2;
	logic                           vld_s2;
	logic signed [PROD_W-1:0]       prod_s3;
	logic                           vld_s3;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [SAMPLE_BITS-1:0]  mean_sel_a;
	logic signed [SAMPLE_BITS-1:0]  mean_sel_b;

	// Means, triangle and division
	logic signed [SAMPLE_BITS-1:0]  mean_mem [MAX_VARS];
	logic signed [SAMPLE_BITS-1:0]  mean_a_q;
	logic signed [SAMPLE_BITS-1:0]  mean_b_q;
	logic signed [scm_pkg::COV_W-1:0] tri_mem [TRI_DEPTH];
	logic signed [scm_pkg::COV_W-1:0] tri_rd_q;
	logic [2*VAR_W-1:0]             tri_raddr;
	logic [CNT_W-1:0]               divisor;
	logic                           div_done;
	logic signed [ACC_W-1:0]        quot;
	logic signed [63:0]             quot_wide;
	logic signed [scm_pkg::COV_W-1:0] cov_sat;

	// Output register
	logic                             out_vld_q;
	logic [scm_pkg::IDX_W-1:0]        row_q;
	logic [scm_pkg::IDX_W-1:0]        col_q;
	logic signed [scm_pkg::COV_W-1:0] cov_q;
	logic                             err_q;
	logic                             last_q;
	logic                             out_free;

	assign samples.ready = cmd.load_en;
	assign accept        = cmd.load_en && samples.valid;
	assign room          = pc_q < CNT_W'(MAX_PATTERNS);
	assign store_we      = accept && room;
	assign store_waddr   = SADDR_W'(wr_base_q + SBASE_W'(var_q));

	// Advance pattern and variable position on each stored word; flag overflow when the store is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= '0;
			var_q     <= '0;
			wr_base_q <= '0;
			ovf_q     <= 1'b0;
		end else if (cmd.restart) begin
			pc_q      <= '0;
			var_q     <= '0;
			wr_base_q <= '0;
			ovf_q     <= 1'b0;
		end else if (accept) begin
			if (!room) begin
				ovf_q <= 1'b1;
			end else if ((CMP_W'(var_q) + CMP_W'(1)) >= CMP_W'(vars)) begin
				var_q     <= '0;
				pc_q      <= pc_q + CNT_W'(1);
				wr_base_q <= wr_base_q + SBASE_W'(MAX_VARS);
			end else begin
				var_q <= var_q + VAR_W'(1);
			end
		end
	end

	// Sample store: one write port, two registered read ports
	assign rd_addr_a = SADDR_W'(rd_base_q + SBASE_W'(row_sel));
	assign rd_addr_b = SADDR_W'(rd_base_q + SBASE_W'(col_sel));

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[store_waddr] <= samples.sample_value;
		end
		rd_a_s1 <= store_mem[rd_addr_a];
		rd_b_s1 <= store_mem[rd_addr_b];
	end

	// Step through patterns during a sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_base_q <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
		end else begin
			vld_s1 <= cmd.sweep_rd;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (cmd.sweep_clr) begin
				rd_base_q <= '0;
			end else if (cmd.sweep_rd) begin
				rd_base_q <= rd_base_q + SBASE_W'(MAX_VARS);
			end
		end
	end

	// Center, multiply, accumulate; plain sum when forming means
	assign mean_sel_a = cmd.cov_mode ? mean_a_q : '0;
	assign mean_sel_b = cmd.cov_mode ? mean_b_q : '0;

	always_ff @(posedge clk) begin
		da_s2 <= DIFF_W'(rd_a_s1) - DIFF_W'(mean_sel_a);
		db_s2 <= DIFF_W'(rd_b_s1) - DIFF_W'(mean_sel_b);
		if (cmd.cov_mode) begin
			prod_s3 <= da_s2 * db_s2;
		end else begin
			prod_s3 <= PROD_W'(da_s2);
		end
		if (cmd.sweep_clr) begin
			acc_q <= '0;
		end else if (vld_s3) begin
			acc_q <= acc_q + ACC_W'(prod_s3);
		end
	end

	// Divide by n for a mean, by n - 1 for a covariance
	assign divisor = cmd.cov_mode ? (pc_q - CNT_W'(1)) : pc_q;

	scm_divider #(
		.DIV_W (ACC_W),
		.DVS_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (acc_q),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quot)
	);

	// Clamp to the Q24.16 range
	always_comb begin
		quot_wide = 64'(quot);
		if (quot_wide > scm_pkg::COV_MAX) begin
			cov_sat = scm_pkg::COV_W'(scm_pkg::COV_MAX);
		end else if (quot_wide < scm_pkg::COV_MIN) begin
			cov_sat = scm_pkg::COV_W'(scm_pkg::COV_MIN);
		end else begin
			cov_sat = scm_pkg::COV_W'(quot_wide);
		end
	end

	// Mean store: written per variable, read for the current pair
	always_ff @(posedge clk) begin
		if (cmd.mean_wr) begin
			mean_mem[row_sel] <= SAMPLE_BITS'(quot);
		end
		mean_a_q <= mean_mem[row_sel];
		mean_b_q <= mean_mem[col_sel];
	end

	// Upper triangle: read mirrored for entries below the diagonal
	assign tri_raddr = (row_sel > col_sel) ? {col_sel, row_sel} : {row_sel, col_sel};

	always_ff @(posedge clk) begin
		if (cmd.tri_wr) begin
			tri_mem[{row_sel, col_sel}] <= cov_sat;
		end
		tri_rd_q <= tri_mem[tri_raddr];
	end

	// Output register: hold a word until taken
	assign out_free = !out_vld_q || entries.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (entries.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			row_q  <= scm_pkg::IDX_W'(row_sel);
			col_q  <= scm_pkg::IDX_W'(col_sel);
			cov_q  <= sts.err ? '0 : tri_rd_q;
			err_q  <= sts.err;
			last_q <= cmd.out_last;
		end
	end

	assign entries.valid      = out_vld_q;
	assign entries.row_index  = row_q;
	assign entries.col_index  = col_q;
	assign entries.cov_value  = cov_q;
	assign entries.error_flag = err_q;
	assign entries.last_entry = last_q;

	// Status toward the controller
	always_comb begin
		sts.last_in   = accept && samples.last_of_set;
		sts.err       = ovf_q || (pc_q < CNT_W'(2));
		sts.pipe_busy = vld_s1 || vld_s2 || vld_s3;
		sts.div_done  = div_done;
		sts.out_free  = out_free;
	end

	assign n_patterns = pc_q;

endmodule

`default_nettype wire

@@ rtl/sample_covariance_matrix.sv @@
// Top level of the unbiased sample covariance block: APB register, controller and datapath.
// Loading takes one sample word per cycle. After the closing word each mean and each
// upper-triangle entry is formed from n patterns read through the two-port sample store,
// then the shared bit-serial divider (ACC_W = 44 by default); entries leave one at a time,
// each held until the output register is free. Reset (arst_n low) clears counters, state
// and vars_in_use to 8; the stores are not cleared.
`default_nettype none

module sample_covariance_matrix #(
	parameter int MAX_VARS     = scm_pkg::MAX_VARS_DEF,
	parameter int MAX_PATTERNS = scm_pkg::MAX_PATTERNS_DEF,
	parameter int SAMPLE_BITS  = scm_pkg::SAMPLE_BITS_DEF,
	localparam int VAR_W  = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1,
	localparam int VCNT_W = $clog2(MAX_VARS + 1),
	localparam int CNT_W  = $clog2(MAX_PATTERNS + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	scm_in_if.sink                              samples,
	scm_out_if.source                           entries,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [scm_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [scm_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [scm_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready
);

	logic [scm_pkg::CFG_W-1:0]     vars_q;
	logic [scm_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          reg_wr;
	logic [VCNT_W-1:0]             vars_act;
	scm_pkg::cmd_t                 cmd;
	scm_pkg::sts_t                 sts;
	logic [VAR_W-1:0]              row_sel;
	logic [VAR_W-1:0]              col_sel;
	logic [CNT_W-1:0]              n_patterns;

	// Register port
	assign pready  = 1'b1;
	assign reg_idx = paddr[scm_pkg::APB_ADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite && pready &&
		(reg_idx == scm_pkg::REG_VARS_IN_USE);
	assign prdata  = (reg_idx == scm_pkg::REG_VARS_IN_USE) ?
		scm_pkg::APB_DATA_W'(vars_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vars_q <= scm_pkg::VARS_RESET;
		end else if (reg_wr) begin
			vars_q <= pwdata[scm_pkg::CFG_W-1:0];
		end
	end

	// Clamp the variable count to 1..MAX_VARS
	always_comb begin
		if (vars_q == '0) begin
			vars_act = VCNT_W'(1);
		end else if (32'(vars_q) > MAX_VARS) begin
			vars_act = VCNT_W'(MAX_VARS);
		end else begin
			vars_act = VCNT_W'(vars_q);
		end
	end

	scm_ctrl #(
		.MAX_VARS     (MAX_VARS),
		.MAX_PATTERNS (MAX_PATTERNS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.vars       (vars_act),
		.n_patterns (n_patterns),
		.sts        (sts),
		.cmd        (cmd),
		.row_sel    (row_sel),
		.col_sel    (col_sel)
	);

	scm_datapath #(
		.MAX_VARS     (MAX_VARS),
		.MAX_PATTERNS (MAX_PATTERNS),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.entries    (entries),
		.cmd        (cmd),
		.row_sel    (row_sel),
		.col_sel    (col_sel),
		.vars       (vars_act),
		.sts        (sts),
		.n_patterns (n_patterns)
	);

endmodule

`default_nettype wire
